FILE: design/uer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TRIGGER_TICKS   = 3'd0,
        CFG_CONFIRM_TICKS   = 3'd1,
        CFG_RISE_POLL_TICKS = 3'd2,
        CFG_FALL_POLL_TICKS = 3'd3,
        CFG_TIMEOUT_TICKS   = 3'd4,
        CFG_PERIOD_TICKS    = 3'd5,
        CFG_NO_ECHO_VALUE   = 3'd6
    } cfg_index_t;

    localparam int CFG_DATA_W = 18;

    // Measurement phases, one-hot
    typedef enum logic [3:0] {
        PH_TRIG = 4'b0001,
        PH_RISE = 4'b0010,
        PH_FALL = 4'b0100,
        PH_IDLE = 4'b1000
    } phase_t;

    localparam logic [9:0]  TRIGGER_TICKS_RST   = 10'd10;
    localparam logic [11:0] CONFIRM_TICKS_RST   = 12'd200;
    localparam logic [11:0] RISE_POLL_TICKS_RST = 12'd200;
    localparam logic [11:0] FALL_POLL_TICKS_RST = 12'd5;
    localparam logic [17:0] TIMEOUT_TICKS_RST   = 18'd20000;
    localparam logic [17:0] PERIOD_TICKS_RST    = 18'd250000;
    localparam logic [15:0] NO_ECHO_VALUE_RST   = 16'd1000;

    // mm = floor(dur * 343 / 2000) is computed as (dur * MM_MULT) >> MM_SHIFT.
    // The reciprocal is exact for every duration below the saturation point.
    localparam int          MM_SHIFT = 31;
    localparam logic [28:0] MM_MULT  = 29'd368293446;
    localparam int          DUR_MUL_W = 19;
    localparam int          PROD_W    = DUR_MUL_W + 29;
    // Smallest duration whose distance exceeds 16 bits
    localparam logic [32:0] SAT_DUR  = 33'd382135;

    typedef struct packed {
        logic echo_level;
    } sample_t;

    typedef struct packed {
        logic        trigger_level;
        logic        result_valid;
        logic [15:0] distance_mm;
        logic        timed_out;
    } result_t;

endpackage

`default_nettype wire

FILE: design/uer_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface uer_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: design/ultrasonic_echo_ranger_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload                                            
// samples   sink       echo_level                                          
// results   source     trigger_level, result_valid, distance_mm, timed_out
// cfg_*     write      register index 0..6, data up to 18 bits
//
// One sample is taken per cycle while the output is not stalled; a result leaves
// through an input register and an output register.
// The period counter, the poll countdown and the distance multiplier are all
// updated within the single step from input register to output register.
// Reset puts the ranger at the start of a trigger phase with default registers.
// A stalled output holds its result; one further sample is held in the input register.

module ultrasonic_echo_ranger_core #(
    parameter int TIME_BITS = 18
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [2:0]                 cfg_index,
    input  wire logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata,
    uer_stream_if.sink                      samples,
    uer_stream_if.source                    results
);
    import uer_pkg::*;

    localparam int CMP_W = (TIME_BITS + 1 > 19) ? TIME_BITS + 1 : 19;

    // Configuration registers
    logic [9:0]  trigger_ticks_reg;
    logic [11:0] confirm_ticks_reg;
    logic [11:0] rise_poll_ticks_reg;
    logic [11:0] fall_poll_ticks_reg;
    logic [17:0] timeout_ticks_reg;
    logic [17:0] period_ticks_reg;
    logic [15:0] no_echo_value_reg;

    // Measurement state
    phase_t                 phase_reg, phase_next;
    logic [TIME_BITS-1:0]   period_reg, period_next;
    logic [11:0]            poll_reg, poll_next;
    logic                   pend_reg, pend_next;
    logic [TIME_BITS-1:0]   cand_reg, cand_next;
    logic [TIME_BITS-1:0]   rise_reg, rise_next;
    logic [15:0]            dist_reg, dist_next;
    logic                   tmo_reg, tmo_next;

    // Pipeline registers
    logic     in_valid_reg;
    sample_t  in_data_reg;
    logic     out_valid_reg;
    result_t  out_data_reg;

    logic                   advance;
    logic                   trig;
    logic                   res_valid;
    logic                   rising;
    logic                   want;
    logic                   done;
    logic [11:0]            poll_ticks;
    logic [TIME_BITS:0]     count_inc;
    logic [32:0]            dur_ext;
    logic [PROD_W-1:0]      prod;
    logic [15:0]            meas_mm;

    function automatic logic [11:0] reload(input logic [11:0] n);
        logic [11:0] r;
        r = (n == 12'd0) ? 12'd0 : n - 12'd1;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_ticks_reg   <= TRIGGER_TICKS_RST;
            confirm_ticks_reg   <= CONFIRM_TICKS_RST;
            rise_poll_ticks_reg <= RISE_POLL_TICKS_RST;
            fall_poll_ticks_reg <= FALL_POLL_TICKS_RST;
            timeout_ticks_reg   <= TIMEOUT_TICKS_RST;
            period_ticks_reg    <= PERIOD_TICKS_RST;
            no_echo_value_reg   <= NO_ECHO_VALUE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_TRIGGER_TICKS:   trigger_ticks_reg   <= cfg_wdata[9:0];
                CFG_CONFIRM_TICKS:   confirm_ticks_reg   <= cfg_wdata[11:0];
                CFG_RISE_POLL_TICKS: rise_poll_ticks_reg <= cfg_wdata[11:0];
                CFG_FALL_POLL_TICKS: fall_poll_ticks_reg <= cfg_wdata[11:0];
                CFG_TIMEOUT_TICKS:   timeout_ticks_reg   <= cfg_wdata[17:0];
                CFG_PERIOD_TICKS:    period_ticks_reg    <= cfg_wdata[17:0];
                CFG_NO_ECHO_VALUE:   no_echo_value_reg   <= cfg_wdata[15:0];
                default:             ;
            endcase
        end
    end

    assign advance       = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !in_valid_reg || advance;

    // In the fall phase the candidate register holds the duration already.
    assign dur_ext = 33'(cand_reg);
    assign prod    = PROD_W'(dur_ext[DUR_MUL_W-1:0]) * PROD_W'(MM_MULT);
    assign meas_mm = (dur_ext >= SAT_DUR) ? 16'hFFFF : prod[MM_SHIFT+15:MM_SHIFT];

    assign count_inc  = {1'b0, period_reg} + (TIME_BITS + 1)'(1);
    assign rising     = (phase_reg == PH_RISE);
    assign want       = rising;
    assign poll_ticks = rising ? rise_poll_ticks_reg : fall_poll_ticks_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        period_next = period_reg;
        poll_next   = poll_reg;
        pend_next   = pend_reg;
        cand_next   = cand_reg;
        rise_next   = rise_reg;
        dist_next   = dist_reg;
        tmo_next    = tmo_reg;
        trig        = 1'b0;
        res_valid   = 1'b0;
        done        = 1'b0;

        case (phase_reg)
            PH_TRIG:
            begin
                trig = 1'b1;
                if (CMP_W'(count_inc) >= CMP_W'(trigger_ticks_reg))
                begin
                    phase_next = PH_RISE;
                    poll_next  = 12'd0;
                    pend_next  = 1'b0;
                end
            end
            PH_RISE, PH_FALL:
            begin
                if (poll_reg != 12'd0)
                begin
                    poll_next = poll_reg - 12'd1;
                end
                else if (!pend_reg)
                begin
                    if (in_data_reg.echo_level == want)
                    begin
                        cand_next = rising ? period_reg : period_reg - rise_reg;
                        pend_next = 1'b1;
                        poll_next = reload(confirm_ticks_reg);
                    end
                    else
                    begin
                        poll_next = reload(poll_ticks);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                    if (in_data_reg.echo_level == want)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        poll_next = reload(poll_ticks);
                    end
                end

                // A confirmed edge takes precedence over the timeout.
                if (done && rising)
                begin
                    rise_next  = cand_reg;
                    phase_next = PH_FALL;
                    poll_next  = 12'd0;
                end
                else if (done)
                begin
                    dist_next  = meas_mm;
                    tmo_next   = 1'b0;
                    res_valid  = 1'b1;
                    phase_next = PH_IDLE;
                end
                else if (CMP_W'(period_reg) >= CMP_W'(timeout_ticks_reg))
                begin
                    dist_next  = no_echo_value_reg;
                    tmo_next   = 1'b1;
                    res_valid  = 1'b1;
                    phase_next = PH_IDLE;
                    pend_next  = 1'b0;
                    poll_next  = 12'd0;
                end
            end
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // Period end, also on overflow of the time counter
        if ((CMP_W'(count_inc) >= CMP_W'(period_ticks_reg)) || count_inc[TIME_BITS])
        begin
            period_next = '0;
            phase_next  = PH_TRIG;
            poll_next   = 12'd0;
            pend_next   = 1'b0;
        end
        else
        begin
            period_next = count_inc[TIME_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TRIG;
            period_reg    <= '0;
            poll_reg      <= 12'd0;
            pend_reg      <= 1'b0;
            cand_reg      <= '0;
            rise_reg      <= '0;
            dist_reg      <= 16'd0;
            tmo_reg       <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (samples.valid && samples.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                period_reg    <= period_next;
                poll_reg      <= poll_next;
                pend_reg      <= pend_next;
                cand_reg      <= cand_next;
                rise_reg      <= rise_next;
                dist_reg      <= dist_next;
                tmo_reg       <= tmo_next;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            in_data_reg <= samples.payload;
        end
        if (advance)
        begin
            out_data_reg.trigger_level <= trig;
            out_data_reg.result_valid  <= res_valid;
            out_data_reg.distance_mm   <= dist_next;
            out_data_reg.timed_out     <= tmo_next;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_data_reg;

endmodule

`default_nettype wire

FILE: bench/ultrasonic_echo_ranger_core_tb.sv
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_core_tb;

    import uer_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          PHASES       = 12;
    localparam int          PHASE_TICKS  = 110;
    localparam int          LONG_TICKS   = 150;

    typedef logic [CFG_DATA_W-1:0] cfg_word_t;

    typedef struct packed {
        logic [9:0]  trig;
        logic [11:0] confirm;
        logic [11:0] rise_poll;
        logic [11:0] fall_poll;
        logic [17:0] timeout;
        logic [17:0] period;
        logic [15:0] no_echo;
    } cfg_set_t;

    typedef enum logic {ROW_SAMPLE, ROW_SETUP} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        setup_no;
        logic        echo;
        logic        typed;
        result_t     want;
    } row_t;

    localparam result_t NO_CHECK       = '{1'b0, 1'b0, 16'd0, 1'b0};
    localparam result_t RESET_TRIGGER  = '{1'b1, 1'b0, 16'd0, 1'b0};
    localparam result_t NO_ECHO_MAX    = '{1'b0, 1'b1, 16'hFFFF, 1'b1};
    localparam result_t TRIG_AFTER_NE  = '{1'b1, 1'b0, 16'hFFFF, 1'b1};
    localparam result_t HOLD_NO_ECHO   = '{1'b0, 1'b0, 16'hFFFF, 1'b1};
    localparam result_t ZERO_DISTANCE  = '{1'b0, 1'b1, 16'd0, 1'b0};

    localparam cfg_set_t DIR_SETUPS [0:1] = '{
        '{10'd0, 12'd0, 12'd0, 12'd0, 18'd0, 18'd3, 16'hFFFF},
        '{10'd2, 12'd1, 12'd1, 12'd1, 18'd262143, 18'd40, 16'd0}
    };

    localparam cfg_set_t LONG_SETTING =
        '{10'd1023, 12'd4095, 12'd4095, 12'd4095, 18'd262143, 18'd262143, 16'd65535};

    localparam int DIR_ROWS = 27;

    // Default registers first: ten trigger ticks, then a rise candidate. The first
    // setup forces an immediate timeout with the largest no-echo value; the second
    // runs a failed rise confirmation and then a three-tick echo of zero distance.
    localparam row_t DIRECTED [0:DIR_ROWS-1] = '{
        '{ROW_SAMPLE, 1'b0, 1'b0, 1'b1, RESET_TRIGGER},
        '{ROW_SAMPLE, 1'b0, 1'b1, 1'b1, RESET_TRIGGER},
        '{ROW_SAMPLE, 1'b0, 1'b0, 1'b1, RESET_TRIGGER},
        '{ROW_SAMPLE, 1'b0, 1'b1, 1'b1, RESET_TRIGGER},
        '{ROW_SAMPLE, 1'b0, 1'b1, 1'b1, RESET_TRIGGER},
        '{ROW_SAMPLE, 1'b0, 1'b0, 1'b1, RESET_TRIGGER},
        '{ROW_SAMPLE, 1'b0, 1'b0, 1'b1, RESET_TRIGGER},
        '{ROW_SAMPLE, 1'b0, 1'b1, 1'b1, RESET_TRIGGER},
        '{ROW_SAMPLE, 1'b0, 1'b0, 1'b1, RESET_TRIGGER},
        '{ROW_SAMPLE, 1'b0, 1'b1, 1'b1, RESET_TRIGGER},
        '{ROW_SAMPLE, 1'b0, 1'b1, 1'b0, NO_CHECK},
        '{ROW_SETUP,  1'b0, 1'b0, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, 1'b0, 1'b0, 1'b1, NO_ECHO_MAX},
        '{ROW_SAMPLE, 1'b0, 1'b1, 1'b1, TRIG_AFTER_NE},
        '{ROW_SAMPLE, 1'b0, 1'b1, 1'b1, NO_ECHO_MAX},
        '{ROW_SAMPLE, 1'b0, 1'b0, 1'b1, HOLD_NO_ECHO},
        '{ROW_SETUP,  1'b1, 1'b0, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, 1'b0, 1'b0, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, 1'b0, 1'b1, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, 1'b0, 1'b1, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, 1'b0, 1'b0, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, 1'b0, 1'b1, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, 1'b0, 1'b1, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, 1'b0, 1'b1, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, 1'b0, 1'b0, 1'b0, NO_CHECK},
        '{ROW_SAMPLE, 1'b0, 1'b0, 1'b1, ZERO_DISTANCE},
        '{ROW_SAMPLE, 1'b0, 1'b1, 1'b0, NO_CHECK}
    };

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [2:0] cfg_index;
    cfg_word_t cfg_wdata;

    uer_stream_if #(.payload_t(sample_t)) samples_ch ();
    uer_stream_if #(.payload_t(result_t)) results_ch ();

    ultrasonic_echo_ranger_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .samples   (samples_ch),
        .results   (results_ch)
    );

    // Ranger state as the block should hold it
    phase_t      rg_phase;
    logic [17:0] rg_count;
    logic [11:0] rg_countdown;
    logic        rg_pending;
    logic [17:0] rg_cand;
    logic [17:0] rg_rise;
    logic [15:0] rg_dist;
    logic        rg_tmo;

    logic [9:0]  cf_trig;
    logic [11:0] cf_confirm;
    logic [11:0] cf_rise_poll;
    logic [11:0] cf_fall_poll;
    logic [17:0] cf_timeout;
    logic [17:0] cf_period;
    logic [15:0] cf_no_echo;

    result_t     tick_results_due [$];

    int unsigned win_lo;
    int unsigned win_hi;
    logic        glitchy = 1'b1;
    int          tx_idle_pct = 20;
    int          rx_idle_pct = 74;
    logic        stall_rx;

    int          ticks_sent = 0;
    int          random_ticks = 0;
    int          ticks_checked = 0;
    int          distances_seen = 0;
    int          timeouts_seen = 0;
    int          settings_applied = 0;
    int          mismatches = 0;
    int          orphans = 0;
    int unsigned cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [11:0] reload_of(input logic [11:0] n);
        return (n == 12'd0) ? 12'd0 : n - 12'd1;
    endfunction

    task automatic reset_ranger();
        cf_trig      = 10'd10;
        cf_confirm   = 12'd200;
        cf_rise_poll = 12'd200;
        cf_fall_poll = 12'd5;
        cf_timeout   = 18'd20000;
        cf_period    = 18'd250000;
        cf_no_echo   = 16'd1000;
        rg_phase     = PH_TRIG;
        rg_count     = '0;
        rg_countdown = '0;
        rg_pending   = 1'b0;
        rg_cand      = '0;
        rg_rise      = '0;
        rg_dist      = '0;
        rg_tmo       = 1'b0;
    endtask

    // Advances the ranger by one tick and returns what the block should emit.
    task automatic predict_tick(input logic echo, output result_t res);
        int unsigned     t;
        int unsigned     next_t;
        logic            trig;
        logic            valid;
        logic            rising;
        logic            want;
        logic            done;
        logic [11:0]     poll;
        logic [17:0]     dur;
        longint unsigned mm;
        t     = rg_count;
        trig  = 1'b0;
        valid = 1'b0;
        done  = 1'b0;
        if (rg_phase == PH_TRIG)
        begin
            trig = 1'b1;
            if (t + 1 >= cf_trig)
            begin
                rg_phase     = PH_RISE;
                rg_countdown = '0;
                rg_pending   = 1'b0;
            end
        end
        else if (rg_phase == PH_RISE || rg_phase == PH_FALL)
        begin
            rising = (rg_phase == PH_RISE);
            want   = rising;
            poll   = rising ? cf_rise_poll : cf_fall_poll;
            if (rg_countdown != 12'd0)
                rg_countdown = rg_countdown - 12'd1;
            else if (!rg_pending)
            begin
                if (echo == want)
                begin
                    rg_cand      = t[17:0];
                    rg_pending   = 1'b1;
                    rg_countdown = reload_of(cf_confirm);
                end
                else
                    rg_countdown = reload_of(poll);
            end
            else
            begin
                rg_pending = 1'b0;
                if (echo == want)
                    done = 1'b1;
                else
                    rg_countdown = reload_of(poll);
            end
            // A confirmed edge takes precedence over the timeout on the same tick.
            if (done && rising)
            begin
                rg_rise      = rg_cand;
                rg_phase     = PH_FALL;
                rg_countdown = '0;
            end
            else if (done)
            begin
                dur      = rg_cand - rg_rise;
                mm       = 64'(dur) * 64'd343 / 64'd2000;
                rg_dist  = (mm > 64'd65535) ? 16'hFFFF : mm[15:0];
                rg_tmo   = 1'b0;
                valid    = 1'b1;
                rg_phase = PH_IDLE;
            end
            else if (t >= cf_timeout)
            begin
                rg_dist      = cf_no_echo;
                rg_tmo       = 1'b1;
                valid        = 1'b1;
                rg_phase     = PH_IDLE;
                rg_pending   = 1'b0;
                rg_countdown = '0;
            end
        end
        next_t = t + 1;
        if (next_t >= cf_period || next_t > 32'h3FFFF)
        begin
            rg_count     = '0;
            rg_phase     = PH_TRIG;
            rg_countdown = '0;
            rg_pending   = 1'b0;
        end
        else
            rg_count = next_t[17:0];
        res = '{trig, valid, rg_dist, rg_tmo};
    endtask

    task automatic write_reg(input cfg_index_t idx, input cfg_word_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_TRIGGER_TICKS:   cf_trig      = val[9:0];
            CFG_CONFIRM_TICKS:   cf_confirm   = val[11:0];
            CFG_RISE_POLL_TICKS: cf_rise_poll = val[11:0];
            CFG_FALL_POLL_TICKS: cf_fall_poll = val[11:0];
            CFG_TIMEOUT_TICKS:   cf_timeout   = val[17:0];
            CFG_PERIOD_TICKS:    cf_period    = val[17:0];
            CFG_NO_ECHO_VALUE:   cf_no_echo   = val[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input cfg_set_t s);
        write_reg(CFG_TRIGGER_TICKS,   cfg_word_t'(s.trig));
        write_reg(CFG_CONFIRM_TICKS,   cfg_word_t'(s.confirm));
        write_reg(CFG_RISE_POLL_TICKS, cfg_word_t'(s.rise_poll));
        write_reg(CFG_FALL_POLL_TICKS, cfg_word_t'(s.fall_poll));
        write_reg(CFG_TIMEOUT_TICKS,   cfg_word_t'(s.timeout));
        write_reg(CFG_PERIOD_TICKS,    cfg_word_t'(s.period));
        write_reg(CFG_NO_ECHO_VALUE,   cfg_word_t'(s.no_echo));
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    function automatic cfg_set_t random_setting();
        cfg_set_t    s;
        int unsigned p;
        p           = $urandom_range(12, 160);
        s.period    = 18'(p);
        s.trig      = ($urandom_range(0, 19) == 0) ? 10'd1023 : 10'($urandom_range(0, 6));
        s.confirm   = ($urandom_range(0, 9) == 0) ? 12'd4095 : 12'($urandom_range(0, 6));
        s.rise_poll = ($urandom_range(0, 9) == 0) ? 12'd4095 : 12'($urandom_range(0, 8));
        s.fall_poll = ($urandom_range(0, 9) == 0) ? 12'd4095 : 12'($urandom_range(0, 8));
        s.timeout   = 18'($urandom_range(0, p + 16));
        s.no_echo   = 16'($urandom());
        return s;
    endfunction

    // Echo window for the coming period, in ticks from its start.
    task automatic pick_window(input logic long_echo);
        int unsigned p;
        int unsigned kind;
        p    = (cf_period < 18'd2) ? 2 : cf_period;
        kind = $urandom_range(0, 5);
        if (long_echo || kind == 0)
        begin
            win_lo = $urandom_range(0, p / 16);
            win_hi = p - p / 8 - $urandom_range(0, p / 16);
        end
        else if (kind == 1)
        begin
            win_lo = 0;
            win_hi = 0;
        end
        else
        begin
            win_lo = $urandom_range(0, p / 2);
            win_hi = win_lo + $urandom_range(1, p / 2);
        end
    endtask

    function automatic logic echo_now();
        logic level;
        level = (rg_count >= win_lo) && (rg_count < win_hi);
        if (glitchy && $urandom_range(0, 39) == 0)
            level = !level;
        return level;
    endfunction

    task automatic idle_gap();
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            samples_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Offers one tick and, once the transaction is taken, records what it must produce.
    task automatic send_sample(input logic echo, input logic typed, input result_t want);
        result_t predicted;
        samples_ch.valid              <= 1'b1;
        samples_ch.payload.echo_level <= echo;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        predict_tick(echo, predicted);
        tick_results_due.push_back(typed ? want : predicted);
        ticks_sent++;
    endtask

    task automatic drain_results();
        samples_ch.valid <= 1'b0;
        while (tick_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        result_t got;
        result_t due;
        results_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && results_ch.valid && results_ch.ready)
            begin
                got = results_ch.payload;
                ticks_checked++;
                if (got.result_valid)
                begin
                    if (got.timed_out)
                        timeouts_seen++;
                    else
                        distances_seen++;
                end
                if (tick_results_due.size() == 0)
                begin
                    orphans++;
                    if (orphans + mismatches <= 10)
                        $display("Result with nothing outstanding: trig %0b valid %0b mm %0d to %0b",
                                 got.trigger_level, got.result_valid, got.distance_mm,
                                 got.timed_out);
                end
                else
                begin
                    due = tick_results_due.pop_front();
                    if (got.trigger_level !== due.trigger_level
                        || got.result_valid !== due.result_valid
                        || got.distance_mm !== due.distance_mm
                        || got.timed_out !== due.timed_out)
                    begin
                        mismatches++;
                        if (orphans + mismatches <= 10)
                            $display({"Result %0d: expected trig %0b valid %0b mm %0d to %0b,",
                                      " got trig %0b valid %0b mm %0d to %0b"},
                                     ticks_checked, due.trigger_level, due.result_valid,
                                     due.distance_mm, due.timed_out, got.trigger_level,
                                     got.result_valid, got.distance_mm, got.timed_out);
                    end
                end
            end
            results_ch.ready <= !stall_rx && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Holds the output off long enough for the block to back up into its input.
    initial
    begin
        stall_rx <= 1'b0;
        wait (random_ticks >= 200);
        stall_rx <= 1'b1;
        repeat (150) @(posedge clk);
        stall_rx <= 1'b0;
    end

    initial
    begin
        row_t     row;
        cfg_set_t setting;
        int       phase_no;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_TRIGGER_TICKS;
        cfg_wdata          <= '0;
        samples_ch.valid   <= 1'b0;
        samples_ch.payload <= '0;
        reset_ranger();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row = DIRECTED[r];
            if (row.kind == ROW_SETUP)
            begin
                drain_results();
                apply_setting(DIR_SETUPS[row.setup_no]);
            end
            else
            begin
                idle_gap();
                send_sample(row.echo, row.typed, row.want);
            end
        end

        for (phase_no = 0; phase_no < PHASES; phase_no++)
        begin
            drain_results();
            setting = random_setting();
            if (phase_no == 0)
            begin
                setting.trig      = '0;
                setting.confirm   = '0;
                setting.rise_poll = '0;
                setting.fall_poll = '0;
            end
            // The last short phase zeroes every register, which gives one-tick
            // periods and leaves the ranger at a period start.
            if (phase_no == PHASES - 1)
                setting = '0;
            apply_setting(setting);
            pick_window(1'b0);
            repeat (PHASE_TICKS)
            begin
                if (random_ticks < 500)
                begin
                    tx_idle_pct = 20;
                    rx_idle_pct = 74;
                end
                else if (random_ticks < 1000)
                begin
                    tx_idle_pct = 74;
                    rx_idle_pct = 20;
                end
                else
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                idle_gap();
                if (rg_count == '0)
                    pick_window(1'b0);
                send_sample(echo_now(), 1'b0, NO_CHECK);
                random_ticks++;
            end
        end

        // A short run with every register at its top value; the trigger pulse
        // outlasts it.
        drain_results();
        apply_setting(LONG_SETTING);
        glitchy = 1'b0;
        repeat (LONG_TICKS)
        begin
            if (rg_count == '0)
                pick_window(1'b1);
            send_sample(echo_now(), 1'b0, NO_CHECK);
        end
        drain_results();

        $display("Ranged %0d ticks over %0d register settings, with idling on both sides",
                 ticks_sent, settings_applied);
        $display("and a long output stall; %0d echo distances, %0d no-echo timeouts seen.",
                 distances_seen, timeouts_seen);
        if (mismatches == 0 && orphans == 0 && tick_results_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: ultrasonic_echo_ranger_core.f
design/uer_pkg.sv
design/uer_stream_if.sv
design/ultrasonic_echo_ranger_core.sv
bench/ultrasonic_echo_ranger_core_tb.sv
